/* hw/rtl/gpio_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_pkg
// Shared widths, bus codes, register map and types of the GPIO port.
// ----------------------------------------------------------------------------
package gpio_pkg;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int OP_W      = 2;
  localparam int LINES_DEF = 32;

  // bus opcodes; the unused code behaves as a plain sample
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

  // register map
  localparam logic [ADDR_W-1:0] ADDR_PINS    = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_OUT     = 3'd1;
  localparam logic [ADDR_W-1:0] ADDR_DIR     = 3'd2;
  localparam logic [ADDR_W-1:0] ADDR_ENABLE  = 3'd3;
  localparam logic [ADDR_W-1:0] ADDR_TRIGGER = 3'd4;
  localparam logic [ADDR_W-1:0] ADDR_SENSE   = 3'd5;
  localparam logic [ADDR_W-1:0] ADDR_PENDING = 3'd6;
  localparam logic [ADDR_W-1:0] ADDR_ACK     = 3'd7;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } bus_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] enable;
    logic [DATA_W-1:0] trigger;
    logic [DATA_W-1:0] sense;
  } irq_cfg_t;

  // ones on the implemented lines
  function automatic logic [DATA_W-1:0] implemented_lines(input int lines);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (i < lines) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

/* hw/rtl/gpio_port_with_pin_interrupts.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_port_with_pin_interrupts
// GPIO port of up to LINES pins with per-line edge or level interrupts. Every
// input transaction samples the pins and may carry one register read or write;
// it produces exactly one output transaction with the read data, the driven
// levels, the drive enables and the interrupt request as they stand after it.
// One transaction is taken every clock while the output is not stalled: an
// input register feeds the register file and interrupt logic, whose result
// lands in an output register. Register state only moves when a result is loaded,
// so out_pins_out, out_pins_drive_enable and out_interrupt_request come
// straight from the state registers. Lines above LINES read as zero and
// never interrupt.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_interrupts
  import gpio_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [ADDR_W-1:0] in_reg_addr,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [DATA_W-1:0] in_pins_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  output logic [DATA_W-1:0] out_pins_out,
  output logic [DATA_W-1:0] out_pins_drive_enable,
  output logic              out_interrupt_request
);

  localparam logic [DATA_W-1:0] LineMask = implemented_lines(LINES);

  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_wdata_r, s1_pins_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] rd_data_r;

  logic              out_free, s1_free, fire;
  bus_cmd_t          cmd;
  irq_cfg_t          cfg;
  logic [DATA_W-1:0] rd_data, ack, pending;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_op_r    <= in_opcode;
      s1_addr_r  <= in_reg_addr;
      s1_wdata_r <= in_write_data & LineMask;
      s1_pins_r  <= in_pins_in & LineMask;
    end
  end

  always_comb begin
    cmd.rd    = (s1_op_r == OP_READ);
    cmd.wr    = (s1_op_r == OP_WRITE);
    cmd.addr  = s1_addr_r;
    cmd.wdata = s1_wdata_r;
  end

  gpio_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .cmd       (cmd),
    .pins      (s1_pins_r),
    .pending   (pending),
    .cfg       (cfg),
    .out_latch (out_pins_out),
    .dir_mask  (out_pins_drive_enable),
    .rd_data   (rd_data),
    .ack       (ack)
  );

  gpio_irq #(
    .LINES (LINES)
  ) u_irq (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .pins    (s1_pins_r),
    .cfg     (cfg),
    .ack     (ack),
    .pending (pending)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) rd_data_r <= rd_data;
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = rd_data_r;
  assign out_interrupt_request = |pending;

endmodule

/* hw/rtl/gpio_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_regs
// Control register file: write decode, read mux and acknowledge strobe.
// ----------------------------------------------------------------------------
module gpio_regs
  import gpio_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  bus_cmd_t          cmd,
  input  logic [DATA_W-1:0] pins,
  input  logic [DATA_W-1:0] pending,
  output irq_cfg_t          cfg,
  output logic [DATA_W-1:0] out_latch,
  output logic [DATA_W-1:0] dir_mask,
  output logic [DATA_W-1:0] rd_data,
  output logic [DATA_W-1:0] ack
);

  logic [DATA_W-1:0] out_r, dir_r, en_r, trig_r, sense_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r   <= '0;
      dir_r   <= '0;
      en_r    <= '0;
      trig_r  <= '0;
      sense_r <= '0;
    end else if (fire && cmd.wr) begin
      unique case (cmd.addr)
        ADDR_OUT:     out_r   <= cmd.wdata;
        ADDR_DIR:     dir_r   <= cmd.wdata;
        ADDR_ENABLE:  en_r    <= cmd.wdata;
        ADDR_TRIGGER: trig_r  <= cmd.wdata;
        ADDR_SENSE:   sense_r <= cmd.wdata;
        default: ;
      endcase
    end
  end

  // reads see the registers as held before this transaction
  always_comb begin
    rd_data = '0;
    if (cmd.rd) begin
      unique case (cmd.addr)
        ADDR_PINS:    rd_data = pins;
        ADDR_OUT:     rd_data = out_r;
        ADDR_DIR:     rd_data = dir_r;
        ADDR_ENABLE:  rd_data = en_r;
        ADDR_TRIGGER: rd_data = trig_r;
        ADDR_SENSE:   rd_data = sense_r;
        ADDR_PENDING: rd_data = pending;
        default:      rd_data = '0;
      endcase
    end
  end

  assign ack         = (cmd.wr && cmd.addr == ADDR_ACK) ? cmd.wdata : '0;
  assign cfg.enable  = en_r;
  assign cfg.trigger = trig_r;
  assign cfg.sense   = sense_r;
  assign out_latch   = out_r;
  assign dir_mask    = dir_r;

endmodule

/* hw/rtl/gpio_irq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_irq
// Per-line edge/level event detection and pending mask.
// ----------------------------------------------------------------------------
module gpio_irq
  import gpio_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [DATA_W-1:0] pins,
  input  irq_cfg_t          cfg,
  input  logic [DATA_W-1:0] ack,
  output logic [DATA_W-1:0] pending
);

  localparam logic [DATA_W-1:0] LineMask = implemented_lines(LINES);

  logic [DATA_W-1:0] pending_r, pending_nxt;
  logic [DATA_W-1:0] prev_r;
  logic [DATA_W-1:0] edge_hit, level_hit, events;

  always_comb begin
    edge_hit  = (cfg.sense & pins & ~prev_r) | (~cfg.sense & prev_r & ~pins);
    level_hit = (cfg.sense & pins) | (~cfg.sense & ~pins);
    events    = ((cfg.trigger & edge_hit) | (~cfg.trigger & level_hit))
                & cfg.enable & LineMask;
    // a fresh event wins over an acknowledge of the same line
    pending_nxt = ((pending_r & ~ack) | events) & LineMask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      prev_r    <= '0;
    end else if (fire) begin
      pending_r <= pending_nxt;
      prev_r    <= pins;
    end
  end

  assign pending = pending_r;

endmodule

/* verif/gpio_port_with_pin_interrupts_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_port_with_pin_interrupts_tb
// Self-checking bench for the GPIO port. A shadow copy of the register file
// and interrupt logic predicts the result of every accepted input transaction.
// Each output transaction is checked field by field against the oldest
// prediction. Directed register, level and edge sequences run first, then
// random bus traffic over wandering pin levels. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_interrupts_tb;
  import gpio_pkg::*;

  localparam int LINES = LINES_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1530;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_WAIT = 17;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pins_out;
    logic [DATA_W-1:0] drive_enable;
    logic              irq;
  } port_view_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode = OP_SAMPLE;
  logic [ADDR_W-1:0] in_reg_addr = ADDR_PINS;
  logic [DATA_W-1:0] in_write_data = '0;
  logic [DATA_W-1:0] in_pins_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic [DATA_W-1:0] out_pins_out;
  logic [DATA_W-1:0] out_pins_drive_enable;
  logic              out_interrupt_request;

  // shadow register file, at its reset values
  logic [DATA_W-1:0] latch_sh = '0, dir_sh = '0, enable_sh = '0;
  logic [DATA_W-1:0] trigger_sh = '0, sense_sh = '0;
  logic [DATA_W-1:0] pend_sh = '0, prev_pins_sh = '0;

  port_view_t        awaited_views[$];
  int                error_count = 0;
  bit                in_quiet = 1'b0;
  bit                out_quiet = 1'b0;
  logic [DATA_W-1:0] pin_level = '0;

  gpio_port_with_pin_interrupts #(.LINES(LINES)) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_reg_addr           (in_reg_addr),
    .in_write_data         (in_write_data),
    .in_pins_in            (in_pins_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_read_data         (out_read_data),
    .out_pins_out          (out_pins_out),
    .out_pins_drive_enable (out_pins_drive_enable),
    .out_interrupt_request (out_interrupt_request)
  );

  always #10 clk = ~clk;

  function automatic logic [DATA_W-1:0] lines_mask();
    if (LINES >= DATA_W) return '1;
    return (DATA_W'(1) << LINES) - DATA_W'(1);
  endfunction

  // Advance the shadow port by one transaction and return what it should show.
  function automatic port_view_t step_port(input logic [OP_W-1:0] op,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [DATA_W-1:0] wdata,
                                           input logic [DATA_W-1:0] pins_raw);
    logic [DATA_W-1:0] m, wd, pins, rise, fall, edge_hit, lvl_hit, hits, ack;
    port_view_t v;
    m        = lines_mask();
    wd       = wdata & m;
    pins     = pins_raw & m;
    rise     = pins & ~prev_pins_sh;
    fall     = prev_pins_sh & ~pins;
    edge_hit = (sense_sh & rise) | (~sense_sh & fall);
    lvl_hit  = (sense_sh & pins) | (~sense_sh & ~pins);
    // detection uses the settings held before this transaction's write
    hits     = ((trigger_sh & edge_hit) | (~trigger_sh & lvl_hit)) & enable_sh & m;
    ack      = '0;
    v.read_data = '0;
    if (op == OP_READ) begin
      case (addr)
        ADDR_PINS:    v.read_data = pins;
        ADDR_OUT:     v.read_data = latch_sh;
        ADDR_DIR:     v.read_data = dir_sh;
        ADDR_ENABLE:  v.read_data = enable_sh;
        ADDR_TRIGGER: v.read_data = trigger_sh;
        ADDR_SENSE:   v.read_data = sense_sh;
        ADDR_PENDING: v.read_data = pend_sh;
        default:      v.read_data = '0;
      endcase
    end
    if (op == OP_WRITE) begin
      case (addr)
        ADDR_OUT:     latch_sh = wd;
        ADDR_DIR:     dir_sh = wd;
        ADDR_ENABLE:  enable_sh = wd;
        ADDR_TRIGGER: trigger_sh = wd;
        ADDR_SENSE:   sense_sh = wd;
        ADDR_ACK:     ack = wd;
        default:      ;
      endcase
    end
    pend_sh      = ((pend_sh & ~ack) | hits) & m;
    prev_pins_sh = pins;
    v.pins_out     = latch_sh;
    v.drive_enable = dir_sh;
    v.irq          = (pend_sh != '0);
    return v;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] seen);
    if (seen !== want) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, seen);
    end
  endtask

  // Prediction first, so a same-edge result would still find its entry.
  always @(posedge clk) begin : scoreboard
    port_view_t got;
    if (rst_n && in_valid && !in_stall)
      awaited_views.push_back(step_port(in_opcode, in_reg_addr, in_write_data, in_pins_in));
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_views.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result transaction: read_data %h", out_read_data);
      end else begin
        got = awaited_views.pop_front();
        check_field("read_data", got.read_data, out_read_data);
        check_field("pins_out", got.pins_out, out_pins_out);
        check_field("pins_drive_enable", got.drive_enable, out_pins_drive_enable);
        check_field("interrupt_request", {{(DATA_W-1){1'b0}}, got.irq},
                    {{(DATA_W-1){1'b0}}, out_interrupt_request});
      end
    end
  end

  // result side back-pressure
  initial begin : result_stall
    int unsigned hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] pins);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_reg_addr   <= addr;
    in_write_data <= wdata;
    in_pins_in    <= pins;
    pin_level     = pins;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic test_register_access();
    send_item(OP_WRITE, ADDR_OUT, '1, '0);
    send_item(OP_READ, ADDR_OUT, '0, '0);
    send_item(OP_WRITE, ADDR_DIR, 32'hA5A5_A5A5, '0);
    send_item(OP_READ, ADDR_DIR, '0, '0);
    // read-only addresses ignore writes
    send_item(OP_WRITE, ADDR_PINS, 32'h1234_5678, '1);
    send_item(OP_READ, ADDR_PINS, '1, '1);
    send_item(OP_WRITE, ADDR_PENDING, '1, '1);
    send_item(OP_READ, ADDR_ACK, '1, '1);
    send_item(OP_SPARE, ADDR_OUT, 32'hDEAD_BEEF, '0);
  endtask

  task automatic test_level_interrupts();
    send_item(OP_WRITE, ADDR_SENSE, '1, '0);
    send_item(OP_WRITE, ADDR_ENABLE, '1, '0);
    send_item(OP_SAMPLE, ADDR_PINS, '0, 32'h0000_FFFF);
    send_item(OP_READ, ADDR_PENDING, '0, '0);
    send_item(OP_WRITE, ADDR_ACK, '1, '0);
    send_item(OP_WRITE, ADDR_SENSE, '0, '1);
    send_item(OP_SAMPLE, ADDR_PINS, '0, 32'hFFFF_FFFE);
    // ack against a level still held: the bit stays set
    send_item(OP_WRITE, ADDR_ACK, 32'h1, 32'hFFFF_FFFE);
    send_item(OP_READ, ADDR_PENDING, '0, 32'hFFFF_FFFE);
  endtask

  task automatic test_edge_interrupts();
    send_item(OP_WRITE, ADDR_TRIGGER, '1, '1);
    send_item(OP_WRITE, ADDR_ACK, '1, '1);
    send_item(OP_SAMPLE, ADDR_PINS, '0, '0);
    send_item(OP_WRITE, ADDR_SENSE, '1, '0);
    send_item(OP_WRITE, ADDR_ACK, '1, '0);
    send_item(OP_SAMPLE, ADDR_PINS, '0, '1);
    send_item(OP_READ, ADDR_PENDING, '0, '1);
    send_item(OP_WRITE, ADDR_ACK, '1, '0);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    int unsigned k;
    k = $urandom_range(0, DATA_W-1);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'(1) << k;
      3:       return ~(DATA_W'(1) << k);
      default: return $urandom;
    endcase
  endfunction

  // mostly a few toggling lines so edges stay sparse
  function automatic logic [DATA_W-1:0] next_pins();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '0;
      2:       return '1;
      3:       return pin_level ^ (DATA_W'(1) << $urandom_range(0, DATA_W-1));
      default: return pin_level ^ ($urandom & $urandom & $urandom);
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    int unsigned       pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 63) == 0) in_quiet = ~in_quiet;
      if ($urandom_range(0, 63) == 0) out_quiet = ~out_quiet;
      pick = $urandom_range(0, 19);
      if (pick < 8)       op = OP_SAMPLE;
      else if (pick < 13) op = OP_READ;
      else if (pick < 19) op = OP_WRITE;
      else                op = OP_SPARE;
      addr = $urandom_range(0, 7);
      send_item(op, addr, pick_word(), next_pins());
    end
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  initial begin : main
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_level_interrupts();
    test_edge_interrupts();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/gpio_pkg.sv
hw/rtl/gpio_regs.sv
hw/rtl/gpio_irq.sv
hw/rtl/gpio_port_with_pin_interrupts.sv
verif/gpio_port_with_pin_interrupts_tb.sv
